// ===== hdl/alrb_pkg.sv =====
// Shared types and constants of the audio loop ring buffer.
package alrb_pkg;

    // Fixed field widths of the item and result ports.
    localparam int SAMPLE_BITS = 16;
    localparam int GAIN_BITS   = 15;
    localparam int IDX_BITS    = 16;
    localparam int SIZE_BITS   = 17;

    // Remainder unit: dividends reach index plus a 17-bit count, so 18 bits.
    localparam int MOD_BITS  = 18;
    localparam int MOD_STEPS = 18;

    // Mix arithmetic: Q2.14 gain times Q1.15 sample, summed, then back to Q1.15.
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int ACC_BITS    = PROD_BITS + 1;
    localparam int ROUND_SHIFT = 14;

    // Configuration register map and reset value.
    localparam int                   CFG_DATA_BITS  = 32;
    localparam int                   CFG_ADDR_BITS  = 3;
    localparam logic [SIZE_BITS-1:0] BUF_SIZE_RESET = 17'd65536;

    typedef enum logic [2:0] {
        REQ_MIX       = 3'd0,
        REQ_PLAY      = 3'd1,
        REQ_END_WRITE = 3'd2,
        REQ_END_PLAY  = 3'd3,
        REQ_DELAY     = 3'd4
    } t_req;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_MOD_WAIT,
        S_POST,
        S_READ,
        S_FETCH,
        S_MUL_NEW,
        S_MUL_OLD,
        S_WRITE,
        S_DONE
    } t_state;

    // Steps of the shared multiplier in the mix unit.
    typedef struct packed {
        logic load;   // product of new gain and new sample
        logic acc;    // add product of current gain and stored sample
    } t_mix_ctrl;

endpackage

// ===== hdl/alrb_modulo.sv =====
// Shift-and-subtract remainder unit, one quotient bit per cycle.
module alrb_modulo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [alrb_pkg::MOD_BITS-1:0]       i_dividend,
    input  logic [alrb_pkg::SIZE_BITS-1:0]      i_divisor,
    output logic                                o_done,
    output logic [alrb_pkg::IDX_BITS-1:0]       o_rem
);
    localparam int CNT_W = $clog2(alrb_pkg::MOD_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(alrb_pkg::MOD_STEPS - 1);

    logic                               r_busy;
    logic                               r_done;
    logic [CNT_W-1:0]                   r_cnt;
    logic [alrb_pkg::MOD_BITS-1:0]      r_x;
    logic [alrb_pkg::SIZE_BITS-1:0]     r_rem;
    logic [alrb_pkg::SIZE_BITS-1:0]     r_divisor;
    logic [alrb_pkg::MOD_BITS-1:0]      w_trial;
    logic [alrb_pkg::MOD_BITS-1:0]      w_diff;
    logic                               w_fit;
    logic [alrb_pkg::SIZE_BITS-1:0]     w_rem_next;

    // The partial remainder stays below the divisor, so the trial fits 18 bits.
    always_comb begin
        w_trial    = {r_rem, r_x[alrb_pkg::MOD_BITS-1]};
        w_diff     = w_trial - {1'b0, r_divisor};
        w_fit      = (w_trial >= {1'b0, r_divisor});
        w_rem_next = w_fit ? alrb_pkg::SIZE_BITS'(w_diff) : alrb_pkg::SIZE_BITS'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x       <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_x   <= {r_x[alrb_pkg::MOD_BITS-2:0], 1'b0};
            r_rem <= w_rem_next;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[alrb_pkg::IDX_BITS-1:0];
endmodule

// ===== hdl/alrb_mix.sv =====
// Crossfade unit: one multiplier used twice, then rounding and saturation.
module alrb_mix (
    input  logic                                    i_clk,
    input  alrb_pkg::t_mix_ctrl                     i_ctrl,
    input  logic signed [alrb_pkg::SAMPLE_BITS-1:0] i_sample_new,
    input  logic signed [alrb_pkg::SAMPLE_BITS-1:0] i_sample_old,
    input  logic [alrb_pkg::GAIN_BITS-1:0]          i_gain_new,
    input  logic [alrb_pkg::GAIN_BITS-1:0]          i_gain_cur,
    output logic signed [alrb_pkg::SAMPLE_BITS-1:0] o_mixed
);
    localparam int Q_BITS = alrb_pkg::ACC_BITS - alrb_pkg::ROUND_SHIFT;
    localparam logic signed [Q_BITS-1:0] Q_HI = Q_BITS'((1 << (alrb_pkg::SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_BITS-1:0] Q_LO = -Q_HI - Q_BITS'(1);
    localparam logic signed [alrb_pkg::ACC_BITS-1:0] HALF_LSB =
        alrb_pkg::ACC_BITS'(1 << (alrb_pkg::ROUND_SHIFT - 1));

    logic [alrb_pkg::GAIN_BITS-1:0]             w_gain;
    logic signed [alrb_pkg::SAMPLE_BITS-1:0]    w_smp;
    logic signed [alrb_pkg::PROD_BITS-1:0]      w_prod;
    logic signed [alrb_pkg::PROD_BITS-1:0]      r_prod;
    logic signed [alrb_pkg::ACC_BITS-1:0]       r_acc;
    logic signed [alrb_pkg::ACC_BITS-1:0]       w_rnd;
    logic signed [Q_BITS-1:0]                   w_q;

    always_comb begin
        w_gain = i_ctrl.acc ? i_gain_cur : i_gain_new;
        w_smp  = i_ctrl.acc ? i_sample_old : i_sample_new;
        w_prod = $signed({1'b0, w_gain}) * w_smp;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_prod <= w_prod;
        end
        if (i_ctrl.acc) begin
            r_acc <= alrb_pkg::ACC_BITS'(r_prod) + alrb_pkg::ACC_BITS'(w_prod);
        end
    end

    // Add half an output step, floor by the arithmetic shift, then clamp.
    always_comb begin
        w_rnd = r_acc + HALF_LSB;
        w_q   = $signed(w_rnd[alrb_pkg::ACC_BITS-1:alrb_pkg::ROUND_SHIFT]);
        if (w_q > Q_HI) begin
            o_mixed = alrb_pkg::SAMPLE_BITS'(Q_HI);
        end else if (w_q < Q_LO) begin
            o_mixed = alrb_pkg::SAMPLE_BITS'(Q_LO);
        end else begin
            o_mixed = alrb_pkg::SAMPLE_BITS'(w_q);
        end
    end
endmodule

// ===== hdl/alrb_ram.sv =====
// Single-port sample memory with registered read data.
module alrb_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_addr,
    input  logic [alrb_pkg::SAMPLE_BITS-1:0]  i_wdata,
    output logic [alrb_pkg::SAMPLE_BITS-1:0]  o_rdata
);
    logic [alrb_pkg::SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [alrb_pkg::SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/audio_loop_ring_buffer.sv =====
// Top level of the audio loop ring buffer: sequencer, index state and ports.
//
//  Channel   Direction  Handshake          Contents
//  request   in         i_valid / o_ready  req_type, sample, gains, offset, count, delay
//  result    out        o_valid / i_ready  read sample and flag, positions, recorded count
//  config    in         psel/penable/pwrite buf_size at byte address 0, read back on prdata
//
// After reset the sample memory is swept to zero, one entry per cycle; o_ready stays
// low meanwhile, while configuration writes are still taken. An item occupies the
// block from acceptance until its result is loaded into the output register; for
// requests that need index reduction, most of that time is the 18-step remainder unit.
// A stalled result holds in the output register; the next item is accepted as soon
// as the block is idle, and only a second finished result waits for the first.
module audio_loop_ring_buffer #(
    // Store depth; the index ports keep 16 bits, so 16 to 65536 entries.
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Request channel.
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [2:0]                              i_req_type,
    input  logic signed [alrb_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic [alrb_pkg::GAIN_BITS-1:0]          i_fade_current,
    input  logic [alrb_pkg::GAIN_BITS-1:0]          i_fade_new,
    input  logic [alrb_pkg::IDX_BITS-1:0]           i_index_offset,
    input  logic [alrb_pkg::SIZE_BITS-1:0]          i_sample_count,
    input  logic                                    i_update_index,
    input  logic [alrb_pkg::SIZE_BITS-1:0]          i_delay_amount,
    // Result channel.
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [alrb_pkg::SAMPLE_BITS-1:0] o_read_sample,
    output logic                                    o_read_valid,
    output logic [alrb_pkg::IDX_BITS-1:0]           o_play_position,
    output logic [alrb_pkg::IDX_BITS-1:0]           o_write_position,
    output logic [alrb_pkg::SIZE_BITS-1:0]          o_recorded_count,
    // Configuration port.
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [alrb_pkg::CFG_ADDR_BITS-1:0]      paddr,
    input  logic [alrb_pkg::CFG_DATA_BITS-1:0]      pwdata,
    output logic [alrb_pkg::CFG_DATA_BITS-1:0]      prdata,
    output logic                                    pready
);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_SAMPLES - 1);
    localparam logic [alrb_pkg::SIZE_BITS-1:0] MAX_SZ = alrb_pkg::SIZE_BITS'(MAX_SAMPLES);

    // Sequencer and control state.
    alrb_pkg::t_state                        r_state, n_state;
    logic [AW-1:0]                           r_clr_addr, n_clr_addr;
    logic [alrb_pkg::SIZE_BITS-1:0]          r_buf_size, n_buf_size;
    logic [alrb_pkg::IDX_BITS-1:0]           r_write_idx, n_write_idx;
    logic [alrb_pkg::IDX_BITS-1:0]           r_play_idx, n_play_idx;
    logic [alrb_pkg::SIZE_BITS-1:0]          r_recorded, n_recorded;
    logic                                    r_out_valid, n_out_valid;

    // Latched request and working payload.
    alrb_pkg::t_req                          r_req, n_req;
    logic signed [alrb_pkg::SAMPLE_BITS-1:0] r_sample, n_sample;
    logic [alrb_pkg::GAIN_BITS-1:0]          r_fade_cur, n_fade_cur;
    logic [alrb_pkg::GAIN_BITS-1:0]          r_fade_new, n_fade_new;
    logic [alrb_pkg::IDX_BITS-1:0]           r_offset, n_offset;
    logic [alrb_pkg::SIZE_BITS-1:0]          r_count, n_count;
    logic                                    r_update, n_update;
    logic [alrb_pkg::SIZE_BITS-1:0]          r_delay, n_delay;
    logic [AW-1:0]                           r_addr, n_addr;
    logic signed [alrb_pkg::SAMPLE_BITS-1:0] r_rd_sample, n_rd_sample;
    logic                                    r_rd_valid, n_rd_valid;

    // Output register payload.
    logic signed [alrb_pkg::SAMPLE_BITS-1:0] r_out_sample, n_out_sample;
    logic                                    r_out_rd_valid, n_out_rd_valid;
    logic [alrb_pkg::IDX_BITS-1:0]           r_out_play, n_out_play;
    logic [alrb_pkg::IDX_BITS-1:0]           r_out_write, n_out_write;
    logic [alrb_pkg::SIZE_BITS-1:0]          r_out_recorded, n_out_recorded;

    // Datapath wires.
    logic [alrb_pkg::SIZE_BITS-1:0]          w_size;
    logic [alrb_pkg::MOD_BITS-1:0]           w_rec_sum;
    logic [alrb_pkg::SIZE_BITS-1:0]          w_behind;
    logic [alrb_pkg::MOD_BITS-1:0]           w_wrap;
    logic [alrb_pkg::SIZE_BITS-1:0]          w_lag;
    logic                                    w_cfg_wr;
    logic                                    w_mod_start;
    logic [alrb_pkg::MOD_BITS-1:0]           w_mod_dividend;
    logic                                    w_mod_done;
    logic [alrb_pkg::IDX_BITS-1:0]           w_mod_rem;
    alrb_pkg::t_mix_ctrl                     w_mix_ctrl;
    logic signed [alrb_pkg::SAMPLE_BITS-1:0] w_mixed;
    logic                                    w_ram_we;
    logic [AW-1:0]                           w_ram_addr;
    logic [alrb_pkg::SAMPLE_BITS-1:0]        w_ram_wdata;
    logic [alrb_pkg::SAMPLE_BITS-1:0]        w_ram_rdata;
    logic                                    w_idle;
    logic                                    w_empty;

    // Ring length in use: zero acts as one, anything past the store as its depth.
    always_comb begin
        if (r_buf_size == '0) begin
            w_size = alrb_pkg::SIZE_BITS'(1);
        end else if (r_buf_size > MAX_SZ) begin
            w_size = MAX_SZ;
        end else begin
            w_size = r_buf_size;
        end
    end

    assign w_idle   = (r_state == alrb_pkg::S_IDLE);
    assign w_empty  = (r_recorded == '0);
    assign w_cfg_wr = psel && penable && pwrite && pready && !paddr[2];

    // Recorded count growth, capped at the ring length.
    assign w_rec_sum = {1'b0, r_recorded} + {1'b0, r_count};

    // Play index a clamped distance behind the reduced write index.
    always_comb begin
        w_behind = (r_delay > w_size) ? w_size : r_delay;
        w_wrap   = {2'b0, w_mod_rem} + {1'b0, w_size} - {1'b0, w_behind};
        w_lag    = {1'b0, w_mod_rem} - w_behind;
    end

    // Operand of the remainder unit for each request type.
    always_comb begin
        case (r_req)
            alrb_pkg::REQ_MIX: begin
                w_mod_dividend = {2'b0, r_write_idx} + {2'b0, r_offset};
            end
            alrb_pkg::REQ_PLAY: begin
                w_mod_dividend = {2'b0, r_play_idx} + {2'b0, r_offset};
            end
            alrb_pkg::REQ_END_WRITE: begin
                w_mod_dividend = {2'b0, r_write_idx} + {1'b0, r_count};
            end
            alrb_pkg::REQ_END_PLAY: begin
                w_mod_dividend = {2'b0, r_play_idx} + {1'b0, r_count};
            end
            alrb_pkg::REQ_DELAY: begin
                w_mod_dividend = {2'b0, r_write_idx};
            end
            default: begin
                w_mod_dividend = '0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            alrb_pkg::S_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = alrb_pkg::S_IDLE;
                end
            end
            alrb_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = alrb_pkg::S_DISPATCH;
                end
            end
            alrb_pkg::S_DISPATCH: begin
                case (r_req)
                    alrb_pkg::REQ_MIX: begin
                        n_state = alrb_pkg::S_MOD_WAIT;
                    end
                    alrb_pkg::REQ_END_WRITE: begin
                        n_state = r_update ? alrb_pkg::S_MOD_WAIT : alrb_pkg::S_DONE;
                    end
                    alrb_pkg::REQ_PLAY, alrb_pkg::REQ_END_PLAY, alrb_pkg::REQ_DELAY: begin
                        n_state = w_empty ? alrb_pkg::S_DONE : alrb_pkg::S_MOD_WAIT;
                    end
                    default: begin
                        n_state = alrb_pkg::S_DONE;
                    end
                endcase
            end
            alrb_pkg::S_MOD_WAIT: begin
                if (w_mod_done) begin
                    n_state = alrb_pkg::S_POST;
                end
            end
            alrb_pkg::S_POST: begin
                if (r_req == alrb_pkg::REQ_MIX || r_req == alrb_pkg::REQ_PLAY) begin
                    n_state = alrb_pkg::S_READ;
                end else begin
                    n_state = alrb_pkg::S_DONE;
                end
            end
            alrb_pkg::S_READ: begin
                n_state = (r_req == alrb_pkg::REQ_MIX) ? alrb_pkg::S_MUL_NEW
                                                       : alrb_pkg::S_FETCH;
            end
            alrb_pkg::S_FETCH: begin
                n_state = alrb_pkg::S_DONE;
            end
            alrb_pkg::S_MUL_NEW: begin
                n_state = alrb_pkg::S_MUL_OLD;
            end
            alrb_pkg::S_MUL_OLD: begin
                n_state = alrb_pkg::S_WRITE;
            end
            alrb_pkg::S_WRITE: begin
                n_state = alrb_pkg::S_DONE;
            end
            alrb_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = alrb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = alrb_pkg::S_IDLE;
            end
        endcase
    end

    // State outputs and register updates.
    always_comb begin
        n_clr_addr     = r_clr_addr;
        n_buf_size     = r_buf_size;
        n_write_idx    = r_write_idx;
        n_play_idx     = r_play_idx;
        n_recorded     = r_recorded;
        n_out_valid    = r_out_valid;
        n_req          = r_req;
        n_sample       = r_sample;
        n_fade_cur     = r_fade_cur;
        n_fade_new     = r_fade_new;
        n_offset       = r_offset;
        n_count        = r_count;
        n_update       = r_update;
        n_delay        = r_delay;
        n_addr         = r_addr;
        n_rd_sample    = r_rd_sample;
        n_rd_valid     = r_rd_valid;
        n_out_sample   = r_out_sample;
        n_out_rd_valid = r_out_rd_valid;
        n_out_play     = r_out_play;
        n_out_write    = r_out_write;
        n_out_recorded = r_out_recorded;
        w_mod_start    = 1'b0;
        w_mix_ctrl     = '0;
        w_ram_we       = 1'b0;
        w_ram_addr     = r_addr;
        w_ram_wdata    = w_mixed;

        if (w_cfg_wr) begin
            n_buf_size = pwdata[alrb_pkg::SIZE_BITS-1:0];
        end

        // The downstream side empties the output register on its own.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            alrb_pkg::S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_clr_addr;
                w_ram_wdata = '0;
                n_clr_addr  = r_clr_addr + 1'b1;
            end
            alrb_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_req       = alrb_pkg::t_req'(i_req_type);
                    n_sample    = i_sample_in;
                    n_fade_cur  = i_fade_current;
                    n_fade_new  = i_fade_new;
                    n_offset    = i_index_offset;
                    n_count     = i_sample_count;
                    n_update    = i_update_index;
                    n_delay     = i_delay_amount;
                    n_rd_sample = '0;
                    n_rd_valid  = 1'b0;
                end
            end
            alrb_pkg::S_DISPATCH: begin
                w_mod_start = (n_state == alrb_pkg::S_MOD_WAIT);
                if (r_req == alrb_pkg::REQ_END_WRITE) begin
                    n_recorded = (w_rec_sum > {1'b0, w_size})
                               ? w_size : w_rec_sum[alrb_pkg::SIZE_BITS-1:0];
                end
                if ((r_req == alrb_pkg::REQ_END_PLAY || r_req == alrb_pkg::REQ_DELAY)
                    && w_empty) begin
                    n_play_idx = '0;
                end
            end
            alrb_pkg::S_POST: begin
                case (r_req)
                    alrb_pkg::REQ_MIX, alrb_pkg::REQ_PLAY: begin
                        n_addr = AW'(w_mod_rem);
                    end
                    alrb_pkg::REQ_END_WRITE: begin
                        n_write_idx = w_mod_rem;
                    end
                    alrb_pkg::REQ_END_PLAY: begin
                        n_play_idx = w_mod_rem;
                    end
                    alrb_pkg::REQ_DELAY: begin
                        n_play_idx = (w_behind > {1'b0, w_mod_rem})
                                   ? w_wrap[alrb_pkg::IDX_BITS-1:0]
                                   : w_lag[alrb_pkg::IDX_BITS-1:0];
                    end
                    default: begin
                        n_addr = r_addr;
                    end
                endcase
            end
            alrb_pkg::S_FETCH: begin
                n_rd_sample = $signed(w_ram_rdata);
                n_rd_valid  = 1'b1;
            end
            alrb_pkg::S_MUL_NEW: begin
                w_mix_ctrl.load = 1'b1;
            end
            alrb_pkg::S_MUL_OLD: begin
                w_mix_ctrl.acc = 1'b1;
            end
            alrb_pkg::S_WRITE: begin
                w_ram_we = 1'b1;
            end
            alrb_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid    = 1'b1;
                    n_out_sample   = r_rd_sample;
                    n_out_rd_valid = r_rd_valid;
                    n_out_play     = r_play_idx;
                    n_out_write    = r_write_idx;
                    n_out_recorded = r_recorded;
                end
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alrb_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_buf_size  <= alrb_pkg::BUF_SIZE_RESET;
            r_write_idx <= '0;
            r_play_idx  <= '0;
            r_recorded  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_buf_size  <= n_buf_size;
            r_write_idx <= n_write_idx;
            r_play_idx  <= n_play_idx;
            r_recorded  <= n_recorded;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req          <= n_req;
        r_sample       <= n_sample;
        r_fade_cur     <= n_fade_cur;
        r_fade_new     <= n_fade_new;
        r_offset       <= n_offset;
        r_count        <= n_count;
        r_update       <= n_update;
        r_delay        <= n_delay;
        r_addr         <= n_addr;
        r_rd_sample    <= n_rd_sample;
        r_rd_valid     <= n_rd_valid;
        r_out_sample   <= n_out_sample;
        r_out_rd_valid <= n_out_rd_valid;
        r_out_play     <= n_out_play;
        r_out_write    <= n_out_write;
        r_out_recorded <= n_out_recorded;
    end

    alrb_modulo u_modulo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dividend),
        .i_divisor  (w_size),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    alrb_mix u_mix (
        .i_clk        (i_clk),
        .i_ctrl       (w_mix_ctrl),
        .i_sample_new (r_sample),
        .i_sample_old ($signed(w_ram_rdata)),
        .i_gain_new   (r_fade_new),
        .i_gain_cur   (r_fade_cur),
        .o_mixed      (w_mixed)
    );

    alrb_ram #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // Ports.
    assign o_ready          = w_idle;
    assign o_valid          = r_out_valid;
    assign o_read_sample    = r_out_sample;
    assign o_read_valid     = r_out_rd_valid;
    assign o_play_position  = r_out_play;
    assign o_write_position = r_out_write;
    assign o_recorded_count = r_out_recorded;
    assign pready           = 1'b1;
    assign prdata           = paddr[2] ? '0 : alrb_pkg::CFG_DATA_BITS'(r_buf_size);

    // An accepted item is dispatched in the very next cycle.
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == alrb_pkg::S_DISPATCH))
        else $error("accepted item was not dispatched");

    // The remainder unit only finishes while the sequencer waits for it.
    a_mod_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == alrb_pkg::S_MOD_WAIT))
        else $error("remainder finished outside its wait state");

    // A reduced play index always lies inside the ring.
    a_play_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == alrb_pkg::S_POST
         && (r_req == alrb_pkg::REQ_END_PLAY || r_req == alrb_pkg::REQ_DELAY))
        |=> ({1'b0, r_play_idx} < w_size))
        else $error("play index outside the ring");

    // An end write leaves the recorded count capped at the ring length.
    a_rec_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == alrb_pkg::S_DISPATCH && r_req == alrb_pkg::REQ_END_WRITE)
        |=> (r_recorded <= w_size))
        else $error("recorded count above ring length");

    // A result leaves the done state only by landing in the output register.
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == alrb_pkg::S_DONE && (!r_out_valid || i_ready))
        |=> (r_out_valid && r_state == alrb_pkg::S_IDLE))
        else $error("finished item not loaded into output register");
endmodule

// ===== verif/tb_audio_loop_ring_buffer.sv =====
// Self-checking testbench for the audio loop ring buffer with its own looper prediction.
`timescale 1ns / 100ps

module tb_audio_loop_ring_buffer;
    import alrb_pkg::*;

    // The store depth of the instance, which is also the ceiling of the effective ring length.
    localparam int unsigned MAX_DEPTH = 65536;
    // The request field is three bits wide, so codes past the set delay are reserved.
    localparam int unsigned REQ_CODES = 8;
    // The only register, buf_size, is register zero at byte address zero.
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_BUF_SIZE = '0;
    // Watchdog limit for the whole run; most of a normal run is the clearing sweep.
    localparam int unsigned CYCLE_LIMIT = 1000000;
    // A result is loaded within this tail after its item is taken.
    localparam int unsigned TAIL_CYCLES = 40;

    // One request item, one field per port of the request channel.
    typedef struct packed {
        logic [2:0]                  kind;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [GAIN_BITS-1:0]        fade_current;
        logic [GAIN_BITS-1:0]        fade_new;
        logic [IDX_BITS-1:0]         index_offset;
        logic [SIZE_BITS-1:0]        sample_count;
        logic                        update_index;
        logic [SIZE_BITS-1:0]        delay_amount;
    } loop_req_t;

    // One result item as it leaves the block.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                        valid;
        logic [IDX_BITS-1:0]         play_pos;
        logic [IDX_BITS-1:0]         write_pos;
        logic [SIZE_BITS-1:0]        recorded;
    } loop_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [2:0]             i_req_type = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample_in = '0;
    logic [GAIN_BITS-1:0]   i_fade_current = '0;
    logic [GAIN_BITS-1:0]   i_fade_new = '0;
    logic [IDX_BITS-1:0]    i_index_offset = '0;
    logic [SIZE_BITS-1:0]   i_sample_count = '0;
    logic                   i_update_index = 1'b0;
    logic [SIZE_BITS-1:0]   i_delay_amount = '0;

    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_read_sample;
    logic                   o_read_valid;
    logic [IDX_BITS-1:0]    o_play_position;
    logic [IDX_BITS-1:0]    o_write_position;
    logic [SIZE_BITS-1:0]   o_recorded_count;

    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    // The looper as this testbench believes it to be: the sample tape, both indices, the
    // recorded count and the programmed ring length.
    logic signed [SAMPLE_BITS-1:0] tape [0:MAX_DEPTH-1];
    int unsigned wr_pos;
    int unsigned pl_pos;
    int unsigned rec_cnt;
    int unsigned ring_len;

    // Results owed by the block, oldest first.
    loop_res_t loop_results_due [$];
    loop_res_t seen_res;
    loop_res_t due_res;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    // When set, both sides run back to back with no idle cycles.
    bit no_gaps = 1'b0;

    audio_loop_ring_buffer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_req_type      (i_req_type),
        .i_sample_in     (i_sample_in),
        .i_fade_current  (i_fade_current),
        .i_fade_new      (i_fade_new),
        .i_index_offset  (i_index_offset),
        .i_sample_count  (i_sample_count),
        .i_update_index  (i_update_index),
        .i_delay_amount  (i_delay_amount),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_read_sample   (o_read_sample),
        .o_read_valid    (o_read_valid),
        .o_play_position (o_play_position),
        .o_write_position(o_write_position),
        .o_recorded_count(o_recorded_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #6 i_clk = ~i_clk;

    // The watchdog. A hung handshake shows up here rather than as a silent hang.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_count, loop_results_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Counts a mismatch and tells whether it is still among the ones worth printing.
    function automatic bit log_mismatch();
        mismatch_count++;
        return mismatch_count <= 10;
    endfunction

    // The effective ring length: zero behaves as one, anything past the depth as the depth.
    function automatic int unsigned ring_span(input int unsigned len);
        if (len == 0) begin
            return 1;
        end
        return (len > MAX_DEPTH) ? MAX_DEPTH : len;
    endfunction

    // Serves one request against the looper state and returns the result it must produce.
    // Indices are reduced by the current span where they are used, never when the span
    // changes, so stale indices from a larger ring are handled exactly as the block must.
    function automatic loop_res_t predict_looper(input loop_req_t r);
        int unsigned sz;
        int unsigned pos;
        int unsigned grown;
        int unsigned w;
        int unsigned behind;
        longint acc;
        longint q;
        loop_res_t res;
        sz = ring_span(ring_len);
        res.sample = '0;
        res.valid = 1'b0;
        case (r.kind)
            REQ_MIX: begin
                pos = (wr_pos + r.index_offset) % sz;
                // Exact Q2.14 times Q1.15 sum; add half an LSB and floor, so ties go up.
                acc = longint'(r.fade_new) * longint'(r.sample_in)
                    + longint'(r.fade_current) * longint'(tape[pos]);
                q = (acc + 8192) >>> 14;
                if (q > 32767) begin
                    q = 32767;
                end
                if (q < -32768) begin
                    q = -32768;
                end
                tape[pos] = q[SAMPLE_BITS-1:0];
            end
            REQ_PLAY: begin
                // Nothing recorded yet means there is no loop to play.
                if (rec_cnt != 0) begin
                    pos = (pl_pos + r.index_offset) % sz;
                    res.sample = tape[pos];
                    res.valid = 1'b1;
                end
            end
            REQ_END_WRITE: begin
                // This is also where a count left above a shrunk ring gets capped.
                grown = rec_cnt + r.sample_count;
                rec_cnt = (grown > sz) ? sz : grown;
                if (r.update_index) begin
                    wr_pos = (wr_pos + r.sample_count) % sz;
                end
            end
            REQ_END_PLAY: begin
                pl_pos = (rec_cnt == 0) ? 0 : (pl_pos + r.sample_count) % sz;
            end
            REQ_DELAY: begin
                if (rec_cnt == 0) begin
                    pl_pos = 0;
                end else begin
                    w = wr_pos % sz;
                    behind = (r.delay_amount > sz) ? sz : r.delay_amount;
                    pl_pos = (behind > w) ? w + sz - behind : w - behind;
                end
            end
            default: begin
                // Reserved codes leave everything alone and only report positions.
            end
        endcase
        res.play_pos = pl_pos[IDX_BITS-1:0];
        res.write_pos = wr_pos[IDX_BITS-1:0];
        res.recorded = rec_cnt[SIZE_BITS-1:0];
        return res;
    endfunction

    // A request of the given kind with every field random, edges favored. The span sets
    // the scale of counts and delays so that they usually fall near the ring length.
    function automatic loop_req_t random_req(input logic [2:0] kind, input int unsigned span);
        loop_req_t r;
        r.kind = kind;
        case ($urandom_range(0, 7))
            0: r.sample_in = 16'sh8000;
            1: r.sample_in = 16'sh7fff;
            default: r.sample_in = SAMPLE_BITS'($urandom());
        endcase
        r.fade_current = ($urandom_range(0, 9) == 0) ? GAIN_BITS'($urandom())
                                                     : GAIN_BITS'($urandom_range(0, 16384));
        r.fade_new = ($urandom_range(0, 9) == 0) ? GAIN_BITS'($urandom())
                                                 : GAIN_BITS'($urandom_range(0, 16384));
        r.index_offset = IDX_BITS'($urandom());
        r.sample_count = ($urandom_range(0, 4) == 0) ? SIZE_BITS'($urandom())
                                                     : SIZE_BITS'($urandom_range(0, span + 2));
        r.update_index = 1'($urandom());
        r.delay_amount = ($urandom_range(0, 4) == 0) ? SIZE_BITS'($urandom())
                                                     : SIZE_BITS'($urandom_range(0, span + 2));
        return r;
    endfunction

    // Offers one item after a random gap and predicts it at the edge where it is taken.
    // Called and returning at a falling edge, so that a back-to-back item keeps valid high.
    task automatic send_request(input loop_req_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type     <= r.kind;
        i_sample_in    <= r.sample_in;
        i_fade_current <= r.fade_current;
        i_fade_new     <= r.fade_new;
        i_index_offset <= r.index_offset;
        i_sample_count <= r.sample_count;
        i_update_index <= r.update_index;
        i_delay_amount <= r.delay_amount;
        i_valid        <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        loop_results_due.push_back(predict_looper(r));
        @(negedge i_clk);
    endtask

    // Stops offering items and waits until every owed result has come back. Since each
    // item produces a result, the block is idle once the last one is taken.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (loop_results_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_read_check(input logic [CFG_ADDR_BITS-1:0] addr,
                                  input logic [CFG_DATA_BITS-1:0] want);
        logic [CFG_DATA_BITS-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            if (log_mismatch()) begin
                $display("Register read at %0d: expected %0d, got %0d", addr, want, got);
            end
        end
    endtask

    // Reprograms the ring length once the block is idle and reads it back.
    task automatic set_ring_len(input int unsigned len);
        drain_results();
        cfg_write(ADDR_BUF_SIZE, CFG_DATA_BITS'(len));
        ring_len = len;
        @(negedge i_clk);
        cfg_read_check(ADDR_BUF_SIZE, CFG_DATA_BITS'(len));
    endtask

    // Requests against an empty looper: reads are invalid, end play and delay park the
    // play index at zero, and reserved codes only report positions.
    task automatic test_empty_requests();
        loop_req_t r;
        cfg_read_check(ADDR_BUF_SIZE, CFG_DATA_BITS'(BUF_SIZE_RESET));
        r = random_req(REQ_PLAY, 16);
        r.index_offset = '0;
        send_request(r);
        r = random_req(REQ_END_PLAY, 16);
        r.sample_count = 17'd5;
        send_request(r);
        r = random_req(REQ_DELAY, 16);
        r.delay_amount = 17'd100;
        send_request(r);
        for (int k = REQ_DELAY + 1; k < REQ_CODES; k++) begin
            send_request(random_req(3'(k), 16));
        end
        // A zero-length end write leaves the count at zero, so play stays invalid.
        r = random_req(REQ_END_WRITE, 16);
        r.sample_count = '0;
        r.update_index = 1'b1;
        send_request(r);
        r = random_req(REQ_PLAY, 16);
        send_request(r);
    endtask

    // Mix arithmetic at its edges: rounding ties both ways, saturation both ways, and an
    // offset that wraps the write index around the full ring.
    task automatic test_mix_rounding();
        loop_req_t r;
        r = random_req(REQ_MIX, 16);
        r.sample_in = 16'sd1;
        r.fade_new = 15'd8192;
        r.fade_current = '0;
        r.index_offset = 16'd10;
        send_request(r);
        r.sample_in = -16'sd1;
        r.index_offset = 16'd11;
        send_request(r);
        r.sample_in = 16'sh7fff;
        r.fade_new = 15'h7fff;
        r.fade_current = 15'h7fff;
        r.index_offset = 16'd12;
        send_request(r);
        r.sample_in = 16'sh8000;
        r.fade_current = '0;
        r.index_offset = 16'd13;
        send_request(r);
        // A huge count fills the ring and pins the recorded count at its length.
        r = random_req(REQ_END_WRITE, 16);
        r.sample_count = 17'h1ffff;
        r.update_index = 1'b0;
        send_request(r);
        for (int k = 10; k < 14; k++) begin
            r = random_req(REQ_PLAY, 16);
            r.index_offset = 16'(k);
            send_request(r);
        end
        r = random_req(REQ_END_WRITE, 16);
        r.sample_count = 17'd65535;
        r.update_index = 1'b1;
        send_request(r);
        r = random_req(REQ_MIX, 16);
        r.index_offset = 16'hffff;
        send_request(r);
        // The longest delay is clamped to the ring length.
        r = random_req(REQ_DELAY, 16);
        r.delay_amount = 17'h1ffff;
        send_request(r);
        r = random_req(REQ_PLAY, 16);
        r.index_offset = 16'hffff;
        send_request(r);
        r = random_req(REQ_END_PLAY, 16);
        r.sample_count = 17'h1ffff;
        send_request(r);
    endtask

    // Ring lengths out of the normal range and a shrink below the recorded count, which
    // leaves stale indices and a count that only the next end write caps.
    task automatic test_ring_limits();
        loop_req_t r;
        set_ring_len(0);
        r = random_req(REQ_MIX, 1);
        r.index_offset = 16'hffff;
        send_request(r);
        r = random_req(REQ_PLAY, 1);
        r.index_offset = 16'd777;
        send_request(r);
        set_ring_len(17'h1ffff);
        r = random_req(REQ_END_PLAY, MAX_DEPTH);
        r.sample_count = 17'd70000;
        send_request(r);
        set_ring_len(3);
        r = random_req(REQ_PLAY, 3);
        r.index_offset = 16'd2;
        send_request(r);
        r = random_req(REQ_DELAY, 3);
        r.delay_amount = 17'd2;
        send_request(r);
        r = random_req(REQ_END_WRITE, 3);
        r.sample_count = '0;
        r.update_index = 1'b0;
        send_request(r);
        r = random_req(REQ_END_PLAY, 3);
        r.sample_count = 17'd4;
        send_request(r);
    endtask

    // Random traffic at one ring length. Most of it is whole loop passes: a run of mix
    // writes, the end write that commits them, reads of the same stretch, then an end
    // play or a delay. The rest is loose requests of any code, reserved ones included.
    task automatic test_random_loops(input int unsigned len, input int quota, input bit steady);
        loop_req_t r;
        int sent;
        int blk;
        int base;
        int unsigned span;
        span = ring_span(len);
        set_ring_len(len);
        no_gaps = steady;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 9) < 7) begin
                blk = $urandom_range(1, 12);
                base = $urandom_range(0, 3);
                for (int k = 0; k < blk; k++) begin
                    r = random_req(REQ_MIX, span);
                    r.index_offset = IDX_BITS'(base + k);
                    send_request(r);
                end
                r = random_req(REQ_END_WRITE, span);
                r.sample_count = SIZE_BITS'(blk);
                r.update_index = ($urandom_range(0, 3) != 0);
                send_request(r);
                for (int k = 0; k < blk; k++) begin
                    r = random_req(REQ_PLAY, span);
                    r.index_offset = IDX_BITS'(base + k);
                    send_request(r);
                end
                if ($urandom_range(0, 2) == 0) begin
                    r = random_req(REQ_DELAY, span);
                end else begin
                    r = random_req(REQ_END_PLAY, span);
                    r.sample_count = SIZE_BITS'(blk);
                end
                send_request(r);
                sent += 2 * blk + 2;
            end else begin
                repeat (4) begin
                    send_request(random_req(3'($urandom_range(0, REQ_CODES - 1)), span));
                end
                sent += 4;
            end
        end
        drain_results();
        no_gaps = 1'b0;
    endtask

    // The receiving side: a random stall before each result, none while no_gaps is set.
    initial begin
        int stall;
        @(negedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // Every result taken is compared field by field with the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_res.sample = o_read_sample;
            seen_res.valid = o_read_valid;
            seen_res.play_pos = o_play_position;
            seen_res.write_pos = o_write_position;
            seen_res.recorded = o_recorded_count;
            if (loop_results_due.size() == 0) begin
                if (log_mismatch()) begin
                    $display("Result with none owed: sample %0d valid %0d play %0d write %0d rec %0d",
                             seen_res.sample, seen_res.valid, seen_res.play_pos,
                             seen_res.write_pos, seen_res.recorded);
                end
            end else begin
                due_res = loop_results_due.pop_front();
                if (seen_res.sample !== due_res.sample || seen_res.valid !== due_res.valid
                        || seen_res.play_pos !== due_res.play_pos
                        || seen_res.write_pos !== due_res.write_pos
                        || seen_res.recorded !== due_res.recorded) begin
                    if (log_mismatch()) begin
                        $display("Mismatch at cycle %0d", cycle_count);
                        $display("  expected sample %0d valid %0d play %0d write %0d rec %0d",
                                 due_res.sample, due_res.valid, due_res.play_pos,
                                 due_res.write_pos, due_res.recorded);
                        $display("  actual   sample %0d valid %0d play %0d write %0d rec %0d",
                                 seen_res.sample, seen_res.valid, seen_res.play_pos,
                                 seen_res.write_pos, seen_res.recorded);
                    end
                end
            end
        end
    end

    // The test sequence. The block sweeps its store after reset with o_ready low, so the
    // first item simply waits out that sweep.
    initial begin
        foreach (tape[k]) begin
            tape[k] = '0;
        end
        wr_pos = 0;
        pl_pos = 0;
        rec_cnt = 0;
        ring_len = BUF_SIZE_RESET;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_requests();
        test_mix_rounding();
        test_ring_limits();

        // Small rings wrap constantly; the full and oversized settings exercise the top.
        test_random_loops(16, 200, 1'b0);
        test_random_loops(1, 120, 1'b0);
        test_random_loops(5, 160, 1'b1);
        test_random_loops(64, 200, 1'b0);
        test_random_loops(MAX_DEPTH, 200, 1'b0);
        test_random_loops(0, 100, 1'b0);
        test_random_loops(17'h1ffff, 120, 1'b1);
        test_random_loops(3, 150, 1'b0);
        test_random_loops(37, 200, 1'b0);
        test_random_loops(MAX_DEPTH - 1, 200, 1'b0);

        drain_results();
        // Give a stray extra result time to show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
